### rtl/alfl_pkg.sv
// Shared types and codes for the array linked list with free list.
package alfl_pkg;

  // Links are seven bits wide; the all-ones code is the null marker.
  localparam int LINK_W = 7;
  localparam logic [LINK_W-1:0] NULL_SLOT = 7'd127;
  localparam int SLOT_OUT_W = 6;

  // Request codes
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_APPEND = 3'd1;
  localparam logic [2:0] REQ_DELETE = 3'd2;
  localparam logic [2:0] REQ_PRINT  = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_PRINT = 2'd3;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] record_no;
    logic [63:0]        name_low;
    logic [15:0]        name_high;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic signed [31:0]    out_record_no;
    logic [63:0]           out_name_low;
    logic [15:0]           out_name_high;
    logic [SLOT_OUT_W-1:0] slot_used;
    logic                  last_result;
  } result_t;

  // Payload of one stored record
  typedef struct packed {
    logic signed [31:0] record_no;
    logic [63:0]        name_low;
    logic [15:0]        name_high;
  } rec_t;

  typedef struct packed {
    rec_t              rec;
    logic [LINK_W-1:0] next;
  } node_t;

  // Node memory write: record lane and link lane have their own enables
  typedef struct packed {
    logic              data_we;
    logic              link_we;
    logic [LINK_W-1:0] addr;
    node_t             node;
  } node_wr_t;

  typedef struct packed {
    logic              we;
    logic [LINK_W-1:0] addr;
    logic [LINK_W-1:0] link;
  } free_wr_t;

endpackage

### rtl/alfl_store.sv
// Slot store: node memory (record and next link lanes) and free link memory.
module alfl_store #(
  parameter int LIST_SLOTS = 64
) (
  input  logic                        clk,
  input  alfl_pkg::node_wr_t          node_wr,
  input  logic [alfl_pkg::LINK_W-1:0] node_raddr,
  output alfl_pkg::node_t             node_rdata,
  input  alfl_pkg::free_wr_t          free_wr,
  input  logic [alfl_pkg::LINK_W-1:0] free_raddr,
  output logic [alfl_pkg::LINK_W-1:0] free_rdata
);

  localparam int IDX_W = $clog2(LIST_SLOTS);

  alfl_pkg::rec_t              data_mem [LIST_SLOTS];
  logic [alfl_pkg::LINK_W-1:0] link_mem [LIST_SLOTS];
  logic [alfl_pkg::LINK_W-1:0] free_mem [LIST_SLOTS];

  // Node memory: lane writes, registered read
  always_ff @(posedge clk) begin
    if (node_wr.data_we) begin
      data_mem[node_wr.addr[IDX_W-1:0]] <= node_wr.node.rec;
    end
    if (node_wr.link_we) begin
      link_mem[node_wr.addr[IDX_W-1:0]] <= node_wr.node.next;
    end
    node_rdata.rec  <= data_mem[node_raddr[IDX_W-1:0]];
    node_rdata.next <= link_mem[node_raddr[IDX_W-1:0]];
  end

  // Free link memory
  always_ff @(posedge clk) begin
    if (free_wr.we) begin
      free_mem[free_wr.addr[IDX_W-1:0]] <= free_wr.link;
    end
    free_rdata <= free_mem[free_raddr[IDX_W-1:0]];
  end

endmodule

### rtl/array_linked_list_free_list_unit.sv
// Top level of the array linked list with free list: request sequencer and result register.
//
// A request is taken when start is high and busy is low; its results come out of a
// register, one per cycle, each marked by result_valid for exactly one cycle and
// taken by the receiver at once, the final one with last_result set. Append walks the
// list one node memory read per cycle, and print gives its L results on consecutive
// cycles. The walks are paced by the one read port of the node memory, whose
// registered link output drives the next read address. Slots come from the top of
// the freed-slot stack before never-used slots; a full store is answered with status
// full.
module array_linked_list_free_list_unit #(
  parameter int LIST_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  alfl_pkg::req_t    req,
  output logic              result_valid,
  output alfl_pkg::result_t result
);

  localparam int CNT_W = $clog2(LIST_SLOTS + 1);
  localparam int LW    = alfl_pkg::LINK_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_DEL   = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;
  localparam logic [2:0] S_PRINT = 3'd6;

  function automatic logic slot_ok(input logic [LW-1:0] s);
    return s < LW'(LIST_SLOTS);
  endfunction

  logic [2:0]         state, state_next;
  logic [LW-1:0]      head, head_next;
  logic [LW-1:0]      free_head, free_head_next;
  logic [LW-1:0]      fresh, fresh_next;
  logic [LW-1:0]      cur, cur_next;
  logic [LW-1:0]      alloc, alloc_next;
  logic [CNT_W-1:0]   steps, steps_next;
  logic               append_q, append_next;
  alfl_pkg::req_t     req_q, req_next;
  logic               res_valid_next;
  alfl_pkg::result_t  res_next;

  alfl_pkg::node_wr_t node_wr;
  logic [LW-1:0]      node_raddr;
  alfl_pkg::node_t    node_q;
  alfl_pkg::free_wr_t free_wr;
  logic [LW-1:0]      free_q;

  logic [LW-1:0]      nx;
  logic [LW-1:0]      take_s;
  logic               take_ok;
  logic               print_last;

  alfl_store #(
    .LIST_SLOTS(LIST_SLOTS)
  ) u_store (
    .clk       (clk),
    .node_wr   (node_wr),
    .node_raddr(node_raddr),
    .node_rdata(node_q),
    .free_wr   (free_wr),
    .free_raddr(free_head),
    .free_rdata(free_q)
  );

  assign busy = (state != S_IDLE);
  assign nx   = node_q.next;

  // Sequencer
  always_comb begin
    state_next     = state;
    head_next      = head;
    free_head_next = free_head;
    fresh_next     = fresh;
    cur_next       = cur;
    alloc_next     = alloc;
    steps_next     = steps;
    append_next    = append_q;
    req_next       = req_q;
    res_valid_next = 1'b0;
    res_next       = '0;
    node_raddr     = head;
    node_wr        = '0;
    free_wr        = '0;
    take_s         = free_head;
    take_ok        = 1'b0;
    print_last     = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next             = req;
          res_next.last_result = 1'b1;
          unique case (req.req_type)
            alfl_pkg::REQ_INSERT: begin
              append_next = 1'b0;
              state_next  = S_ALLOC;
            end
            alfl_pkg::REQ_APPEND: begin
              if (slot_ok(head)) begin
                append_next = 1'b1;
                cur_next    = head;
                steps_next  = '0;
                state_next  = S_WALK;
              end else begin
                append_next = 1'b0;
                state_next  = S_ALLOC;
              end
            end
            alfl_pkg::REQ_DELETE: begin
              if (slot_ok(head)) begin
                state_next = S_DEL;
              end else begin
                res_valid_next  = 1'b1;
                res_next.status = alfl_pkg::ST_EMPTY;
              end
            end
            alfl_pkg::REQ_PRINT: begin
              if (slot_ok(head)) begin
                cur_next   = head;
                steps_next = '0;
                state_next = S_PRINT;
              end else begin
                res_valid_next  = 1'b1;
                res_next.status = alfl_pkg::ST_EMPTY;
              end
            end
            alfl_pkg::REQ_CLEAR: begin
              if (slot_ok(head)) begin
                steps_next = '0;
                state_next = S_CLEAR;
              end else begin
                res_valid_next = 1'b1;
              end
            end
            default: begin
              res_valid_next = 1'b1;
            end
          endcase
        end
      end

      // Follow next links to the tail
      S_WALK: begin
        if (slot_ok(nx) && (steps < CNT_W'(LIST_SLOTS))) begin
          cur_next   = nx;
          steps_next = steps + CNT_W'(1);
          node_raddr = nx;
        end else begin
          state_next = S_ALLOC;
        end
      end

      // Take a slot and write the new node
      S_ALLOC: begin
        res_next.last_result = 1'b1;
        if (slot_ok(free_head)) begin
          take_s         = free_head;
          take_ok        = 1'b1;
          free_head_next = free_q;
        end else if (fresh < LW'(LIST_SLOTS)) begin
          take_s     = fresh;
          take_ok    = 1'b1;
          fresh_next = fresh + LW'(1);
        end
        if (take_ok) begin
          node_wr.data_we        = 1'b1;
          node_wr.link_we        = 1'b1;
          node_wr.addr           = take_s;
          node_wr.node.rec.record_no = req_q.record_no;
          node_wr.node.rec.name_low  = req_q.name_low;
          node_wr.node.rec.name_high = req_q.name_high;
          node_wr.node.next      = append_q ? alfl_pkg::NULL_SLOT : head;
          if (append_q) begin
            alloc_next = take_s;
            state_next = S_LINK;
          end else begin
            head_next          = take_s;
            res_valid_next     = 1'b1;
            res_next.slot_used = take_s[alfl_pkg::SLOT_OUT_W-1:0];
            state_next         = S_IDLE;
          end
        end else begin
          res_valid_next  = 1'b1;
          res_next.status = alfl_pkg::ST_FULL;
          state_next      = S_IDLE;
        end
      end

      // Hook the new node behind the old tail
      S_LINK: begin
        node_wr.link_we      = 1'b1;
        node_wr.addr         = cur;
        node_wr.node.next    = alloc;
        res_valid_next       = 1'b1;
        res_next.last_result = 1'b1;
        res_next.slot_used   = alloc[alfl_pkg::SLOT_OUT_W-1:0];
        state_next           = S_IDLE;
      end

      // Drop the head onto the free stack
      S_DEL: begin
        head_next            = nx;
        free_wr.we           = 1'b1;
        free_wr.addr         = head;
        free_wr.link         = free_head;
        free_head_next       = head;
        res_valid_next       = 1'b1;
        res_next.last_result = 1'b1;
        res_next.slot_used   = head[alfl_pkg::SLOT_OUT_W-1:0];
        state_next           = S_IDLE;
      end

      // Release one node a cycle, head first
      S_CLEAR: begin
        head_next      = nx;
        free_wr.we     = 1'b1;
        free_wr.addr   = head;
        free_wr.link   = free_head;
        free_head_next = head;
        steps_next     = steps + CNT_W'(1);
        if (slot_ok(nx) && (steps < CNT_W'(LIST_SLOTS - 1))) begin
          node_raddr = nx;
        end else begin
          res_valid_next       = 1'b1;
          res_next.last_result = 1'b1;
          state_next           = S_IDLE;
        end
      end

      // One printed record a cycle
      S_PRINT: begin
        print_last             = !slot_ok(nx) || (steps == CNT_W'(LIST_SLOTS - 1));
        res_valid_next         = 1'b1;
        res_next.status        = alfl_pkg::ST_PRINT;
        res_next.out_record_no = node_q.rec.record_no;
        res_next.out_name_low  = node_q.rec.name_low;
        res_next.out_name_high = node_q.rec.name_high;
        res_next.slot_used     = cur[alfl_pkg::SLOT_OUT_W-1:0];
        res_next.last_result   = print_last;
        if (print_last) begin
          state_next = S_IDLE;
        end else begin
          cur_next   = nx;
          steps_next = steps + CNT_W'(1);
          node_raddr = nx;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= alfl_pkg::NULL_SLOT;
      free_head    <= alfl_pkg::NULL_SLOT;
      fresh        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      head         <= head_next;
      free_head    <= free_head_next;
      fresh        <= fresh_next;
      result_valid <= res_valid_next;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    cur      <= cur_next;
    alloc    <= alloc_next;
    steps    <= steps_next;
    append_q <= append_next;
    req_q    <= req_next;
    result   <= res_next;
  end

  // Every request ends with a final result beat
  a_end_beat: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (result_valid && result.last_result))
    else $error("busy dropped without a final result");

  // Only printed records come in multi-beat bursts
  a_burst_print: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last_result) |-> (result.status == alfl_pkg::ST_PRINT))
    else $error("non-final result that is not a printed record");

  // A print burst has no gaps
  a_burst_gapless: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last_result) |=> result_valid)
    else $error("gap inside a print burst");

  // The list head is never also on the free stack top
  a_head_free: assert property (@(posedge clk) disable iff (rst)
    slot_ok(head) |-> (head != free_head))
    else $error("list head equals free stack top");

  // Fresh slot count moves only on an allocation and stays within the store
  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    (fresh != $past(fresh)) |-> (fresh <= LW'(LIST_SLOTS) && $past(state) == S_ALLOC))
    else $error("fresh slot count out of range");

endmodule

### tb/tb_array_linked_list_free_list_unit.sv
// Self-checking testbench for the array linked list with free list unit.
module tb_array_linked_list_free_list_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SLOTS = 64;
  localparam int LW      = alfl_pkg::LINK_W;
  // Request codes the block ignores
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

  // Expected-result store plus a cycle-free model of the slot store
  class free_list_scoreboard;
    logic [31:0]       number_mem [N_SLOTS];
    logic [63:0]       name_low_mem [N_SLOTS];
    logic [15:0]       name_high_mem [N_SLOTS];
    logic [LW-1:0]     next_mem [N_SLOTS];
    logic [LW-1:0]     free_mem [N_SLOTS];
    logic [LW-1:0]     head;
    logic [LW-1:0]     free_top;
    int                fresh;
    int                error_count;
    alfl_pkg::result_t pending_results [$];

    function new();
      for (int i = 0; i < N_SLOTS; i++) begin
        number_mem[i] = '0;
        name_low_mem[i] = '0;
        name_high_mem[i] = '0;
        next_mem[i] = '0;
        free_mem[i] = '0;
      end
      head = alfl_pkg::NULL_SLOT;
      free_top = alfl_pkg::NULL_SLOT;
      fresh = 0;
      error_count = 0;
    endfunction

    function bit slot_ok(logic [LW-1:0] s);
      return s < N_SLOTS;
    endfunction

    function bit store_full();
      return !slot_ok(free_top) && fresh == N_SLOTS;
    endfunction

    // Most recently freed slot first, then a never-used one
    function logic [LW-1:0] take_slot();
      logic [LW-1:0] s;
      if (slot_ok(free_top)) begin
        s = free_top;
        free_top = free_mem[s];
        return s;
      end
      if (fresh < N_SLOTS) begin
        s = LW'(fresh);
        fresh++;
        return s;
      end
      return alfl_pkg::NULL_SLOT;
    endfunction

    function void drop_head();
      logic [LW-1:0] s;
      s = head;
      head = next_mem[s];
      free_mem[s] = free_top;
      free_top = s;
    endfunction

    function void push(logic [1:0] st, logic [31:0] no, logic [63:0] nlo,
                       logic [15:0] nhi, logic [LW-1:0] slot, bit last);
      alfl_pkg::result_t r;
      r.status = st;
      r.out_record_no = no;
      r.out_name_low = nlo;
      r.out_name_high = nhi;
      r.slot_used = slot[alfl_pkg::SLOT_OUT_W-1:0];
      r.last_result = last;
      pending_results.push_back(r);
    endfunction

    function void write_node(logic [LW-1:0] s, alfl_pkg::req_t r, logic [LW-1:0] link);
      number_mem[s] = r.record_no;
      name_low_mem[s] = r.name_low;
      name_high_mem[s] = r.name_high;
      next_mem[s] = link;
    endfunction

    // Work out the results of one accepted request
    function void note_request(alfl_pkg::req_t r);
      logic [LW-1:0] s;
      logic [LW-1:0] tail;
      logic [LW-1:0] nx;
      bit            last;
      if (r.req_type == alfl_pkg::REQ_INSERT ||
          (r.req_type == alfl_pkg::REQ_APPEND && !slot_ok(head))) begin
        s = take_slot();
        if (!slot_ok(s)) begin
          push(alfl_pkg::ST_FULL, '0, '0, '0, '0, 1'b1);
          return;
        end
        write_node(s, r, head);
        head = s;
        push(alfl_pkg::ST_DONE, '0, '0, '0, s, 1'b1);
        return;
      end
      case (r.req_type)
        alfl_pkg::REQ_APPEND: begin
          tail = head;
          for (int n = 0; n < N_SLOTS && slot_ok(next_mem[tail]); n++)
            tail = next_mem[tail];
          s = take_slot();
          if (!slot_ok(s)) begin
            push(alfl_pkg::ST_FULL, '0, '0, '0, '0, 1'b1);
          end else begin
            write_node(s, r, alfl_pkg::NULL_SLOT);
            next_mem[tail] = s;
            push(alfl_pkg::ST_DONE, '0, '0, '0, s, 1'b1);
          end
        end
        alfl_pkg::REQ_DELETE: begin
          if (!slot_ok(head)) begin
            push(alfl_pkg::ST_EMPTY, '0, '0, '0, '0, 1'b1);
          end else begin
            s = head;
            drop_head();
            push(alfl_pkg::ST_DONE, '0, '0, '0, s, 1'b1);
          end
        end
        alfl_pkg::REQ_PRINT: begin
          if (!slot_ok(head)) begin
            push(alfl_pkg::ST_EMPTY, '0, '0, '0, '0, 1'b1);
          end else begin
            s = head;
            for (int k = 0; k < N_SLOTS; k++) begin
              nx = next_mem[s];
              last = !slot_ok(nx) || k == N_SLOTS - 1;
              push(alfl_pkg::ST_PRINT, number_mem[s], name_low_mem[s], name_high_mem[s],
                   s, last);
              if (last) break;
              s = nx;
            end
          end
        end
        alfl_pkg::REQ_CLEAR: begin
          for (int n = 0; n < N_SLOTS && slot_ok(head); n++)
            drop_head();
          push(alfl_pkg::ST_DONE, '0, '0, '0, '0, 1'b1);
        end
        default: push(alfl_pkg::ST_DONE, '0, '0, '0, '0, 1'b1);
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
    endtask

    // Compare one result beat with the oldest expectation
    task check_result(alfl_pkg::result_t got);
      alfl_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result beat with nothing expected: %h", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.out_record_no !== want.out_record_no)
        report($sformatf("record_no %h, want %h", got.out_record_no, want.out_record_no));
      if (got.out_name_low !== want.out_name_low)
        report($sformatf("name_low %h, want %h", got.out_name_low, want.out_name_low));
      if (got.out_name_high !== want.out_name_high)
        report($sformatf("name_high %h, want %h", got.out_name_high, want.out_name_high));
      if (got.slot_used !== want.slot_used)
        report($sformatf("slot_used %0d, want %0d", got.slot_used, want.slot_used));
      if (got.last_result !== want.last_result)
        report($sformatf("last_result %b, want %b", got.last_result, want.last_result));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  alfl_pkg::req_t    req;
  logic              result_valid;
  alfl_pkg::result_t result;

  free_list_scoreboard sb;
  int burst_left;

  array_linked_list_free_list_unit #(.LIST_SLOTS(N_SLOTS)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result beats cannot be held off; take each one as it comes
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  // Random record with an occasional extreme value in each field
  function alfl_pkg::req_t make_req(logic [2:0] kind);
    alfl_pkg::req_t r;
    r.req_type = kind;
    r.record_no = $urandom;
    r.name_low = {$urandom, $urandom};
    r.name_high = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      0: r.record_no = 32'h8000_0000;
      1: r.record_no = 32'h7fff_ffff;
      2: r.record_no = '1;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: begin r.name_low = '0; r.name_high = '0; end
      1: begin r.name_low = '1; r.name_high = '1; end
      default: ;
    endcase
    return r;
  endfunction

  function alfl_pkg::req_t fixed_req(logic [2:0] kind, logic [31:0] no, logic [63:0] nlo,
                                     logic [15:0] nhi);
    alfl_pkg::req_t r;
    r.req_type = kind;
    r.record_no = no;
    r.name_low = nlo;
    r.name_high = nhi;
    return r;
  endfunction

  // Bursts: mostly short ones with gaps, now and then a long gap-free run
  function int next_burst();
    if ($urandom_range(0, 5) == 0) return $urandom_range(20, 40);
    return $urandom_range(1, 8);
  endfunction

  // Hold one request until the block takes it, then maybe pause
  task send_req(alfl_pkg::req_t r);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = next_burst();
    end
  endtask

  // Request mix: growing phases favor inserts, shrinking ones deletes
  function logic [2:0] pick_kind(bit grow);
    int w;
    w = $urandom_range(0, 99);
    if (grow) begin
      if (w < 40) return alfl_pkg::REQ_INSERT;
      if (w < 75) return alfl_pkg::REQ_APPEND;
      if (w < 85) return alfl_pkg::REQ_DELETE;
      if (w < 93) return alfl_pkg::REQ_PRINT;
      if (w < 95) return alfl_pkg::REQ_CLEAR;
    end else begin
      if (w < 15) return alfl_pkg::REQ_INSERT;
      if (w < 25) return alfl_pkg::REQ_APPEND;
      if (w < 80) return alfl_pkg::REQ_DELETE;
      if (w < 90) return alfl_pkg::REQ_PRINT;
      if (w < 95) return alfl_pkg::REQ_CLEAR;
    end
    return 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
  endfunction

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    burst_left = next_burst();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-list cases and ignored codes
    send_req(make_req(alfl_pkg::REQ_PRINT));
    send_req(make_req(alfl_pkg::REQ_DELETE));
    send_req(make_req(alfl_pkg::REQ_CLEAR));
    for (int t = REQ_SPARE_FIRST; t <= REQ_SPARE_LAST; t++) send_req(make_req(3'(t)));
    // Append to an empty list lands at the head; field extremes
    send_req(fixed_req(alfl_pkg::REQ_APPEND, 32'h8000_0000, '0, '0));
    send_req(fixed_req(alfl_pkg::REQ_INSERT, 32'h7fff_ffff, '1, '1));
    send_req(fixed_req(alfl_pkg::REQ_INSERT, '0, 64'h0123_4567_89ab_cdef, 16'h5aa5));
    send_req(fixed_req(alfl_pkg::REQ_APPEND, '1, 64'hfedc_ba98_7654_3210, 16'ha55a));
    send_req(make_req(alfl_pkg::REQ_PRINT));
    send_req(make_req(alfl_pkg::REQ_DELETE));
    send_req(make_req(alfl_pkg::REQ_APPEND));
    send_req(make_req(alfl_pkg::REQ_PRINT));
    // Clear a list, then reuse the freed slots with the old tail on top
    send_req(make_req(alfl_pkg::REQ_CLEAR));
    send_req(make_req(alfl_pkg::REQ_PRINT));
    send_req(make_req(alfl_pkg::REQ_INSERT));
    send_req(make_req(alfl_pkg::REQ_APPEND));
    send_req(make_req(alfl_pkg::REQ_DELETE));
    send_req(make_req(alfl_pkg::REQ_DELETE));
    send_req(make_req(alfl_pkg::REQ_DELETE));
    send_req(make_req(alfl_pkg::REQ_PRINT));

    // Fill the store, hit the full case, print the longest list
    while (!sb.store_full())
      send_req(make_req($urandom_range(0, 1) ? alfl_pkg::REQ_INSERT : alfl_pkg::REQ_APPEND));
    send_req(make_req(alfl_pkg::REQ_INSERT));
    send_req(make_req(alfl_pkg::REQ_APPEND));
    send_req(make_req(alfl_pkg::REQ_PRINT));
    repeat (10) send_req(make_req(alfl_pkg::REQ_DELETE));
    repeat (5)
      send_req(make_req($urandom_range(0, 1) ? alfl_pkg::REQ_INSERT : alfl_pkg::REQ_APPEND));
    send_req(make_req(alfl_pkg::REQ_PRINT));
    send_req(make_req(alfl_pkg::REQ_CLEAR));

    // Random: alternate growing and shrinking phases
    for (int round = 0; round < 6; round++) begin
      repeat (58) send_req(make_req(pick_kind(round % 2 == 0)));
    end

    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_800_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
